### sv/fcsg_pkg.sv
`timescale 1ns / 1ps

package fcsg_pkg;

    // field widths
    localparam int COORD_W    = 9;
    localparam int RADIUS_W   = 6;
    localparam int COLOUR_W   = 16;
    localparam int POS_W      = 11;
    localparam int SPAN_W     = 7;
    localparam int STEP_W     = 6;
    localparam int DEC_W      = 10;
    localparam int CNT_W      = 6;

    // beat widths: 9+9+6+16 and 4*11 + 2*7 + 2*11 + 16
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;

    // midpoint constants
    localparam int MAX_SPAN_RESULTS = 46;
    localparam int DEC_INIT         = 3;
    localparam int DEC_INC_STRAIGHT = 6;
    localparam int DEC_INC_DIAG     = 10;

    // microprogram
    localparam int PROG_LEN = 2;
    localparam int PC_W     = (PROG_LEN > 1) ? $clog2(PROG_LEN) : 1;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_LOAD = pc_t'(0);
    localparam pc_t STEP_SPAN = pc_t'(1);

    typedef enum logic [1:0] {
        BR_NEXT      = 2'd0,
        BR_JUMP      = 2'd1,
        BR_LOOP_LAST = 2'd2
    } br_t;

    typedef struct packed {
        logic wait_in;
        logic wait_out;
        logic load;
        logic emit;
        br_t  br;
        pc_t  target;
    } ucode_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic last;
    } seq_status_t;

    typedef struct packed {
        logic ready;
        logic span_step;
        logic load_en;
        logic emit_en;
    } seq_ctrl_t;

    function automatic ucode_t prog_word(pc_t pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            STEP_LOAD:
            begin
                // wait for a request beat and latch it
                w.wait_in  = 1'b1;
                w.load     = 1'b1;
                w.br       = BR_NEXT;
                w.target   = STEP_LOAD;
            end
            STEP_SPAN:
            begin
                // one midpoint iteration per free output slot
                w.wait_out = 1'b1;
                w.emit     = 1'b1;
                w.br       = BR_LOOP_LAST;
                w.target   = STEP_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

### sv/filled_circle_span_generator_core.sv
`timescale 1ns / 1ps

// Filled circle span generator. Each request beat on the s_ side (centre, radius,
// colour) is turned into a run of result beats on the m_ side by the midpoint
// circle algorithm: decision starts at 3-2r with x=0, y=r, and one beat is made per
// iteration while y>=x. A beat carries four horizontal fill spans: two of width
// 2x+1 from column cx-x on rows cy-y and cy+y, and two of width 2y+1 from column
// cx-y on rows cy-x and cy+x, plus the colour; tlast marks the final beat of the
// circle. Columns and rows are 11-bit two's complement and may go below zero or
// past 511 near the edges. Radius above MAX_RADIUS is clamped; radius 0 gives a
// single beat. Timing: a request is latched by the load step, then one beat per cycle
// follows while the output is not stalled, about r/sqrt(2)+1 beats, so 45 beats for
// radius 63. The rate is set by the span step of the two-step microprogram, which
// runs one midpoint iteration each cycle that the output slot is free. A new
// request is taken only once the last beat of the previous circle sits in the
// output register.

module filled_circle_span_generator_core
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = 63
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // centre_x, centre_y, radius, fill_colour
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // wide_left, wide_width, wide_top_row, wide_bottom_row, tall_left, tall_width,
    // tall_top_row, tall_bottom_row, span_colour
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tlast
);

    // request fields
    logic [COORD_W-1:0]  in_cx;
    logic [COORD_W-1:0]  in_cy;
    logic [RADIUS_W-1:0] in_radius;
    logic [COLOUR_W-1:0] in_colour;
    logic [RADIUS_W-1:0] radius_clamped;

    // iteration state
    logic [STEP_W-1:0]        x_reg, x_next;
    logic [STEP_W-1:0]        y_reg, y_next;
    logic signed [DEC_W-1:0]  d_reg, d_next;
    logic [COORD_W-1:0]       cx_reg, cx_next;
    logic [COORD_W-1:0]       cy_reg, cy_next;
    logic [COLOUR_W-1:0]      colour_reg, colour_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // output register
    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    // datapath terms
    logic [STEP_W:0]          x_inc;
    logic                     step_down;
    logic [DEC_W-1:0]         x4;
    logic [DEC_W-1:0]         y4;
    logic                     last_geom;
    logic                     last_cnt;
    logic [POS_W-1:0]         cx_ext, cy_ext, x_ext, y_ext;
    logic [POS_W-1:0]         wide_left, wide_top_row, wide_bottom_row;
    logic [POS_W-1:0]         tall_left, tall_top_row, tall_bottom_row;
    logic [SPAN_W-1:0]        wide_width, tall_width;

    seq_status_t status;
    seq_ctrl_t   ctrl;

    fcsg_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    always_comb
    begin
        in_cx     = s_tdata[8:0];
        in_cy     = s_tdata[17:9];
        in_radius = s_tdata[23:18];
        in_colour = s_tdata[39:24];

        radius_clamped = (32'(in_radius) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : in_radius;

        // decision negative: straight step, else diagonal step with y down
        x_inc     = {1'b0, x_reg} + 1'b1;
        step_down = !d_reg[DEC_W-1];
        x4        = DEC_W'({x_reg, 2'b00});
        y4        = DEC_W'({y_reg, 2'b00});

        // loop ends when the updated y falls below the updated x
        last_geom = step_down ? ({1'b0, y_reg} <= x_inc) : (y_reg <= x_reg);
        last_cnt  = (cnt_reg == CNT_W'(MAX_SPAN_RESULTS - 1));

        status.in_valid = s_tvalid;
        status.out_free = !m_tvalid_reg || m_tready;
        status.last     = last_geom || last_cnt;

        // span geometry in 11-bit two's complement
        cx_ext = POS_W'(cx_reg);
        cy_ext = POS_W'(cy_reg);
        x_ext  = POS_W'(x_reg);
        y_ext  = POS_W'(y_reg);

        wide_left       = cx_ext - x_ext;
        wide_width      = {x_reg, 1'b1};
        wide_top_row    = cy_ext - y_ext;
        wide_bottom_row = cy_ext + y_ext;
        tall_left       = cx_ext - y_ext;
        tall_width      = {y_reg, 1'b1};
        tall_top_row    = cy_ext - x_ext;
        tall_bottom_row = cy_ext + x_ext;

        // defaults: hold
        x_next        = x_reg;
        y_next        = y_reg;
        d_next        = d_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        colour_next   = colour_reg;
        cnt_next      = cnt_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (ctrl.load_en)
        begin
            cx_next     = in_cx;
            cy_next     = in_cy;
            colour_next = in_colour;
            x_next      = '0;
            y_next      = radius_clamped;
            d_next      = DEC_W'(DEC_INIT) - DEC_W'({radius_clamped, 1'b0});
            cnt_next    = '0;
        end
        else if (ctrl.emit_en)
        begin
            m_tdata_next  = {colour_reg, tall_bottom_row, tall_top_row, tall_width,
                             tall_left, wide_bottom_row, wide_top_row, wide_width,
                             wide_left};
            m_tlast_next  = status.last;
            m_tvalid_next = 1'b1;

            if (step_down)
            begin
                d_next = d_reg + x4 - y4 + DEC_W'(DEC_INC_DIAG);
                y_next = y_reg - 1'b1;
            end
            else
            begin
                d_next = d_reg + x4 + DEC_W'(DEC_INC_STRAIGHT);
            end
            x_next   = x_inc[STEP_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and iteration registers need no reset
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        d_reg       <= d_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        colour_reg  <= colour_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = ctrl.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // the span step only ever runs inside the loop condition
    a_loop_cond: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.span_step |-> (y_reg >= x_reg))
        else $error("span step entered with y below x");

    // iteration count stays under the bound
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.span_step |-> (cnt_reg < CNT_W'(MAX_SPAN_RESULTS)))
        else $error("iteration count past bound");

    // no new request while a circle is still part-way out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(m_tvalid && !m_tlast))
        else $error("request taken in the middle of a circle");

    // a non-final beat taken is followed straight away by the next one
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a circle run");
`endif

endmodule

### sv/fcsg_sequencer.sv
`timescale 1ns / 1ps

module fcsg_sequencer
    import fcsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output seq_ctrl_t   ctrl
);

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t word;
    logic   go;

    always_comb
    begin
        word = prog_word(pc_reg);
        go   = !(word.wait_in && !status.in_valid) && !(word.wait_out && !status.out_free);

        ctrl.ready     = word.load;
        ctrl.span_step = word.emit;
        ctrl.load_en   = word.load && go;
        ctrl.emit_en   = word.emit && go;

        pc_next = pc_reg;
        if (go)
        begin
            unique case (word.br)
                BR_NEXT:      pc_next = pc_t'(pc_reg + 1'b1);
                BR_JUMP:      pc_next = word.target;
                BR_LOOP_LAST: pc_next = status.last ? word.target : pc_reg;
                default:      pc_next = STEP_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
